// ===== design/affine_point_transform_macros.svh =====
// Assertion macros for the affine point transform.
// Used by design/apt_div_cell.sv and design/affine_point_transform.sv.
`ifndef AFFINE_POINT_TRANSFORM_MACROS_SVH
`define AFFINE_POINT_TRANSFORM_MACROS_SVH

// implication checked on every clock edge outside reset
`define APT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication outside reset
`define APT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/apt_pkg.sv =====
// Shared types, constants and helpers for the affine point transform.
// No dependencies.
package apt_pkg;

   localparam int CoordW  = 32;
   localparam int ProdW   = 64;
   // numerator |n| < 2^81, determinant |d| < 2^65 before the shift
   localparam int NumW    = 82;
   localparam int DenW    = 66;
   localparam int QuotW   = 82;
   localparam int RemW    = DenW + 1;
   localparam int StepsPerCell = 2;
   localparam int NumCells = QuotW / StepsPerCell;
   localparam int CsrIdxW = 3;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_COEF_XX = 3'd0,
      CSR_COEF_XY = 3'd1,
      CSR_COEF_YX = 3'd2,
      CSR_COEF_YY = 3'd3,
      CSR_SHIFT_X = 3'd4,
      CSR_SHIFT_Y = 3'd5
   } csr_idx_type;

   typedef struct packed {
      logic                     mode;
      logic signed [CoordW-1:0] point_x;
      logic signed [CoordW-1:0] point_y;
   } req_type;

   typedef struct packed {
      logic signed [CoordW-1:0] out_x;
      logic signed [CoordW-1:0] out_y;
      logic                     singular;
      logic                     saturated;
   } rsp_type;

   // state carried alongside the divider through every cell
   typedef struct packed {
      logic                     valid;
      logic                     inv;
      logic                     sing;
      logic                     neg_x;
      logic                     neg_y;
      logic signed [CoordW:0]   fwd_x;
      logic signed [CoordW:0]   fwd_y;
      logic [DenW-1:0]          den;
      logic [NumW-1:0]          num_x;
      logic [RemW-1:0]          rem_x;
      logic [NumW-1:0]          num_y;
      logic [RemW-1:0]          rem_y;
   } cell_type;

   // one restoring division step: shift in the top numerator bit
   function automatic logic [RemW+NumW-1:0] div_step(
      input logic [RemW-1:0] rem, input logic [NumW-1:0] num, input logic [DenW-1:0] den);
      logic [RemW:0] trial;
      logic [RemW-1:0] r;
      begin
         r = {rem[RemW-2:0], num[NumW-1]};
         trial = {1'b0, r} - {2'b00, den};
         if (!trial[RemW]) r = trial[RemW-1:0];
         div_step = {r, num[NumW-2:0], ~trial[RemW]};
      end
   endfunction

   function automatic logic [CoordW:0] sat_wide(input logic signed [QuotW:0] v);
      begin
         if (v > $signed({{(QuotW-CoordW+1){1'b0}}, {(CoordW-1){1'b1}}}))
            sat_wide = {2'b10, {(CoordW-1){1'b1}}};
         else if (v < $signed({{(QuotW-CoordW+1){1'b1}}, {(CoordW-1){1'b0}}}))
            sat_wide = {2'b11, {(CoordW-1){1'b0}}};
         else
            sat_wide = {1'b0, v[CoordW-1:0]};
      end
   endfunction

endpackage

// ===== design/apt_div_cell.sv =====
// One cell of the divider chain: two restoring steps on both quotients.
// Depends on apt_pkg and affine_point_transform_macros.svh.
`include "affine_point_transform_macros.svh"
module apt_div_cell (
   input  logic              clock,
   input  logic              reset,
   input  apt_pkg::cell_type cell_i,
   output apt_pkg::cell_type cell_o
);
   import apt_pkg::*;

   cell_type cell_ff, cell_in;

   always_comb begin
      logic [RemW+NumW-1:0] sx, sy;
      cell_in = cell_i;
      for (int s = 0; s < StepsPerCell; s++) begin
         sx = div_step(cell_in.rem_x, cell_in.num_x, cell_in.den);
         sy = div_step(cell_in.rem_y, cell_in.num_y, cell_in.den);
         cell_in.rem_x = sx[RemW+NumW-1:NumW];
         cell_in.num_x = sx[NumW-1:0];
         cell_in.rem_y = sy[RemW+NumW-1:NumW];
         cell_in.num_y = sy[NumW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff <= '0;
      end else begin
         cell_ff <= cell_in;
      end
   end

   assign cell_o = cell_ff;

   `APT_ASSERT_NEXT(a_valid_moves, clock, reset, cell_i.valid, cell_o.valid, "item lost in cell")
   `APT_ASSERT_IMP(a_rem_x_below, clock, reset, cell_o.valid && cell_o.inv && !cell_o.sing,
      cell_o.rem_x < {1'b0, cell_o.den}, "remainder x not below divisor")
   `APT_ASSERT_IMP(a_rem_y_below, clock, reset, cell_o.valid && cell_o.inv && !cell_o.sing,
      cell_o.rem_y < {1'b0, cell_o.den}, "remainder y not below divisor")
endmodule

// ===== design/apt_front.sv =====
// Front end: products, sums and the prepared dividend and divisor.
// Depends on apt_pkg.
module apt_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  apt_pkg::req_type          req_data,
   input  logic signed [31:0]        coef_xx,
   input  logic signed [31:0]        coef_xy,
   input  logic signed [31:0]        coef_yx,
   input  logic signed [31:0]        coef_yy,
   input  logic signed [31:0]        shift_x,
   input  logic signed [31:0]        shift_y,
   output apt_pkg::cell_type         cell_o
);
   import apt_pkg::*;

   // stage 1: operands and products
   logic                      v1_ff, inv1_ff;
   logic signed [CoordW:0]    dx1_ff, dy1_ff;
   logic signed [ProdW:0]     p_a_ff, p_b_ff, p_c_ff, p_d_ff, det_a_ff, det_b_ff;
   logic signed [CoordW-1:0]  sx1_ff, sy1_ff;
   logic signed [CoordW:0]    dx_in, dy_in, ox, oy;

   assign dx_in = CoordW'(0) + req_data.point_x - shift_x;
   assign dy_in = req_data.point_y - shift_y;

   always_comb begin
      ox = req_data.mode ? dx_in : {req_data.point_x[CoordW-1], req_data.point_x};
      oy = req_data.mode ? dy_in : {req_data.point_y[CoordW-1], req_data.point_y};
   end

   // operand pairing: forward a*x,b*y,d*y,c*x ; inverse yy*dx,xy*dy,xx*dy,yx*dx
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start;
      end
      inv1_ff  <= req_data.mode;
      dx1_ff   <= dx_in;
      dy1_ff   <= dy_in;
      sx1_ff   <= shift_x;
      sy1_ff   <= shift_y;
      p_a_ff   <= (req_data.mode ? coef_yy : coef_xx) * ox;
      p_b_ff   <= coef_xy * oy;
      p_c_ff   <= (req_data.mode ? coef_xx : coef_yy) * oy;
      p_d_ff   <= coef_yx * ox;
      det_a_ff <= ProdW'(coef_xx * coef_yy);
      det_b_ff <= ProdW'(coef_xy * coef_yx);
   end

   // stage 2: sums, signs, magnitudes
   logic signed [ProdW+1:0] nx, ny, det;
   logic signed [ProdW+1:0] fx_w, fy_w;
   cell_type cell_in, cell_ff;

   always_comb begin
      logic [ProdW+1:0] ax, ay, ad;
      if (inv1_ff) begin
         nx = p_a_ff - p_b_ff;
         ny = p_c_ff - p_d_ff;
      end else begin
         nx = p_a_ff + p_b_ff;
         ny = p_d_ff + p_c_ff;
      end
      det  = det_a_ff - det_b_ff;
      fx_w = (nx >>> 16) + sx1_ff;
      fy_w = (ny >>> 16) + sy1_ff;
      ax = nx[ProdW+1] ? -nx : nx;
      ay = ny[ProdW+1] ? -ny : ny;
      ad = det[ProdW+1] ? -det : det;
      cell_in = '0;
      cell_in.valid = v1_ff;
      cell_in.inv   = inv1_ff;
      cell_in.sing  = inv1_ff && (det == '0);
      cell_in.neg_x = nx[ProdW+1] ^ det[ProdW+1];
      cell_in.neg_y = ny[ProdW+1] ^ det[ProdW+1];
      cell_in.den   = ad[DenW-1:0];
      cell_in.num_x = {ax[NumW-17:0], 16'd0};
      cell_in.num_y = {ay[NumW-17:0], 16'd0};
      if (!inv1_ff) begin
         cell_in.fwd_x = sat_wide((QuotW+1)'(fx_w));
         cell_in.fwd_y = sat_wide((QuotW+1)'(fy_w));
      end else begin
         cell_in.fwd_x = dx1_ff;
         cell_in.fwd_y = dy1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff <= '0;
      end else begin
         cell_ff <= cell_in;
      end
   end

   assign cell_o = cell_ff;
endmodule

// ===== design/affine_point_transform.sv =====
// Top level of the affine point transform: registers, front end, divider chain.
// Depends on apt_pkg, apt_front, apt_div_cell and the macros header.
//
//   port group  dir  handshake
//   req_*       in   start && !busy
//   rsp_*       out  rsp_valid, one cycle
//   csr_*       in   csr_we
//
// One item per cycle; each item passes the front end's stage 1 and stage 2
// registers, then the divider chain of 41 cells, two quotient bits each.
// Both modes take the same path so results leave in order. busy is always low.
// Reset is synchronous and clears all valid flags; registers return to identity.
`include "affine_point_transform_macros.svh"
module affine_point_transform (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  apt_pkg::req_type           req_data,
   output logic                       rsp_valid,
   output apt_pkg::rsp_type           rsp_data,
   input  logic                       csr_we,
   input  logic [apt_pkg::CsrIdxW-1:0] csr_idx,
   input  logic [31:0]                csr_wdata
);
   import apt_pkg::*;

   logic signed [31:0] xx_ff, xy_ff, yx_ff, yy_ff, tx_ff, ty_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         xx_ff <= 32'sd65536;
         xy_ff <= '0;
         yx_ff <= '0;
         yy_ff <= 32'sd65536;
         tx_ff <= '0;
         ty_ff <= '0;
      end else if (csr_we) begin
         case (csr_idx_type'(csr_idx))
            CSR_COEF_XX: xx_ff <= csr_wdata;
            CSR_COEF_XY: xy_ff <= csr_wdata;
            CSR_COEF_YX: yx_ff <= csr_wdata;
            CSR_COEF_YY: yy_ff <= csr_wdata;
            CSR_SHIFT_X: tx_ff <= csr_wdata;
            CSR_SHIFT_Y: ty_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   cell_type chain [NumCells+1];

   apt_front u_front (
      .clock(clock), .reset(reset), .start(start), .req_data(req_data),
      .coef_xx(xx_ff), .coef_xy(xy_ff), .coef_yx(yx_ff), .coef_yy(yy_ff),
      .shift_x(tx_ff), .shift_y(ty_ff), .cell_o(chain[0])
   );

   for (genvar i = 0; i < NumCells; i++) begin : g_cell
      apt_div_cell u_cell (.clock(clock), .reset(reset), .cell_i(chain[i]),
         .cell_o(chain[i+1]));
   end

   cell_type last;
   logic [CoordW:0] qx, qy, rx, ry;

   always_comb begin
      last = chain[NumCells];
      qx = sat_wide(last.neg_x ? -$signed({1'b0, last.num_x}) : $signed({1'b0, last.num_x}));
      qy = sat_wide(last.neg_y ? -$signed({1'b0, last.num_y}) : $signed({1'b0, last.num_y}));
      if (last.inv && !last.sing) begin
         rx = qx;
         ry = qy;
      end else begin
         rx = last.inv ? sat_wide((QuotW+1)'(last.fwd_x)) : last.fwd_x;
         ry = last.inv ? sat_wide((QuotW+1)'(last.fwd_y)) : last.fwd_y;
      end
      rsp_valid          = last.valid;
      rsp_data.out_x     = rx[CoordW-1:0];
      rsp_data.out_y     = ry[CoordW-1:0];
      rsp_data.singular  = last.sing;
      rsp_data.saturated = rx[CoordW] | ry[CoordW];
   end

   `APT_ASSERT_IMP(a_busy_low, clock, reset, 1'b1, !busy, "busy raised")
   `APT_ASSERT_IMP(a_sing_inv, clock, reset, rsp_valid && rsp_data.singular,
      last.inv, "singular on forward item")
   `APT_ASSERT_IMP(a_rsp_known, clock, reset, rsp_valid,
      !$isunknown(rsp_data), "unknown result data")
endmodule

// ===== bench/affine_point_transform_tb.sv =====
// Self-checking bench for affine_point_transform: forward and inverse point mapping.
// Predicts each result with exact 128-bit arithmetic; depends on apt_pkg and the RTL.
module affine_point_transform_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import apt_pkg::*;

   localparam logic [CsrIdxW-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CsrIdxW-1:0] CSR_SPARE_HI = 3'd7;
   localparam logic signed [127:0] MaxCoord = 128'sd2147483647;
   localparam logic signed [127:0] MinCoord = -128'sd2147483648;
   localparam int DrainCycles = 60;
   localparam int StallLimit = 5000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_data = '0;
   logic rsp_valid;
   rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [CsrIdxW-1:0] csr_idx = '0;
   logic [31:0] csr_wdata = '0;

   // register copy: xx, xy, yx, yy, shift_x, shift_y
   logic signed [31:0] matrix [0:5];
   rsp_type pending_points [$];
   int errors = 0;
   int idle_cycles = 0;

   affine_point_transform dut (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic logic [31:0] clip_coord(input logic signed [127:0] v,
                                              inout logic clipped);
      if (v > MaxCoord) begin
         clipped = 1'b1;
         return 32'h7FFF_FFFF;
      end else if (v < MinCoord) begin
         clipped = 1'b1;
         return 32'h8000_0000;
      end
      return v[31:0];
   endfunction

   function automatic rsp_type transform_point(input req_type r);
      logic signed [127:0] px, py, xx, xy, yx, yy, tx, ty, ox, oy, det, dx, dy;
      rsp_type o;
      logic clipped;
      px = r.point_x;  py = r.point_y;
      xx = matrix[0];  xy = matrix[1];  yx = matrix[2];  yy = matrix[3];
      tx = matrix[4];  ty = matrix[5];
      o = '0;
      clipped = 1'b0;
      if (!r.mode) begin
         ox = ((xx * px + xy * py) >>> 16) + tx;
         oy = ((yx * px + yy * py) >>> 16) + ty;
      end else begin
         dx = px - tx;
         dy = py - ty;
         det = xx * yy - xy * yx;
         if (det == 0) begin
            o.singular = 1'b1;
            ox = dx;
            oy = dy;
         end else begin
            // SV signed division truncates toward zero
            ox = ((yy * dx - xy * dy) <<< 16) / det;
            oy = ((xx * dy - yx * dx) <<< 16) / det;
         end
      end
      o.out_x = clip_coord(ox, clipped);
      o.out_y = clip_coord(oy, clipped);
      o.saturated = clipped;
      return o;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // result checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_points.size() == 0) begin
            $display("unexpected result %p at %0t", rsp_data, $realtime);
            errors++;
         end else begin
            want = pending_points.pop_front();
            if (rsp_data.out_x !== want.out_x)
               report_mismatch("out_x", rsp_data.out_x, want.out_x);
            if (rsp_data.out_y !== want.out_y)
               report_mismatch("out_y", rsp_data.out_y, want.out_y);
            if (rsp_data.singular !== want.singular)
               report_mismatch("singular", rsp_data.singular, want.singular);
            if (rsp_data.saturated !== want.saturated)
               report_mismatch("saturated", rsp_data.saturated, want.saturated);
         end
      end
   end

   // watchdog on lack of progress
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_we)
         idle_cycles <= 0;
      else if (idle_cycles >= StallLimit) begin
         $display("FAILURE");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return $urandom_range(0, 4000) - 2000;
         3: return ($urandom_range(0, 8) - 4) << 16;
         4: return $urandom & 32'h000F_FFFF;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_item(input req_type it);
      @(negedge clock);
      start = 1'b1;
      req_data = it;
      do @(posedge clock); while (busy);
      pending_points.push_back(transform_point(it));
   endtask

   task automatic pause_sender(input int gap);
      if (gap > 0) begin
         @(negedge clock);
         start = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic send_point(input logic mode, input logic [31:0] x, input logic [31:0] y);
      req_type it;
      it.mode = mode;
      it.point_x = x;
      it.point_y = y;
      send_item(it);
      pause_sender(pick_gap());
   endtask

   task automatic drain();
      @(negedge clock);
      start = 1'b0;
      wait (pending_points.size() == 0);
      repeat (DrainCycles) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CsrIdxW-1:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_we = 1'b1;
      csr_idx = idx;
      csr_wdata = value;
      if (idx <= CSR_SHIFT_Y)
         matrix[idx] = value;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic load_matrix(input logic [31:0] xx, xy, yx, yy, tx, ty);
      drain();
      csr_write(CSR_COEF_XX, xx);
      csr_write(CSR_COEF_XY, xy);
      csr_write(CSR_COEF_YX, yx);
      csr_write(CSR_COEF_YY, yy);
      csr_write(CSR_SHIFT_X, tx);
      csr_write(CSR_SHIFT_Y, ty);
   endtask

   task automatic test_identity();
      send_point(1'b0, 32'd0, 32'd0);
      send_point(1'b0, 32'h7FFF_FFFF, 32'h8000_0000);
      send_point(1'b1, 32'h8000_0000, 32'h7FFF_FFFF);
      send_point(1'b1, 32'hFFFF_FFFF, 32'd1);
   endtask

   task automatic test_spare_index();
      // writes past the last register must leave the matrix alone
      drain();
      csr_write(CSR_SPARE_LO, 32'hDEAD_BEEF);
      csr_write(CSR_SPARE_HI, 32'h1234_5678);
      send_point(1'b0, 32'd100, 32'hFFFF_FF00);
      send_point(1'b1, 32'd100, 32'hFFFF_FF00);
   endtask

   task automatic test_saturation();
      load_matrix(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'h8000_0000);
      send_point(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_point(1'b0, 32'h8000_0000, 32'h8000_0000);
      send_point(1'b0, 32'h8000_0000, 32'h7FFF_FFFF);
      send_point(1'b1, 32'h8000_0000, 32'h7FFF_FFFF);
      send_point(1'b1, 32'h7FFF_FFFF, 32'h8000_0000);
      load_matrix(32'd1, 32'd0, 32'd0, 32'd1, 32'h8000_0000, 32'h7FFF_FFFF);
      send_point(1'b1, 32'h7FFF_FFFF, 32'h8000_0000);
      send_point(1'b1, 32'd0, 32'd0);
      send_point(1'b0, 32'h7FFF_FFFF, 32'h8000_0000);
   endtask

   task automatic test_singular();
      // zero determinant from a zero matrix and from equal rows
      load_matrix(32'd0, 32'd0, 32'd0, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000);
      send_point(1'b1, 32'h8000_0000, 32'h7FFF_FFFF);
      send_point(1'b1, 32'd5, 32'hFFFF_FFFB);
      send_point(1'b0, 32'd5, 32'hFFFF_FFFB);
      load_matrix(32'h0002_0000, 32'hFFFF_0000, 32'h0002_0000, 32'hFFFF_0000, 32'd7, 32'd9);
      send_point(1'b1, 32'd1000, 32'hFFFF_F000);
      send_point(1'b0, 32'd1000, 32'hFFFF_F000);
   endtask

   task automatic test_negative_rounding();
      // half scale and negative determinant: floor vs truncation
      load_matrix(32'h0000_8000, 32'd3, 32'hFFFF_FFFD, 32'hFFFF_8000, 32'hFFFF_FFFF, 32'd1);
      send_point(1'b0, 32'hFFFF_FFFF, 32'd1);
      send_point(1'b0, 32'd3, 32'hFFFF_FFFD);
      send_point(1'b1, 32'hFFFF_FFFD, 32'd3);
      send_point(1'b1, 32'd1, 32'hFFFF_FFFF);
   endtask

   task automatic test_random(input int sets, input int per_set);
      logic [31:0] k;
      for (int s = 0; s < sets; s++) begin
         case ($urandom_range(0, 5))
            0: load_matrix(pick_value(), pick_value(), pick_value(), pick_value(),
                           pick_value(), pick_value());
            1: begin
               k = pick_value();
               load_matrix(k, k, k, k, pick_value(), pick_value());
            end
            2: load_matrix(32'd0, pick_value(), 32'd0, pick_value(),
                           pick_value(), pick_value());
            default: load_matrix($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
         endcase
         for (int i = 0; i < per_set; i++) begin
            if ($urandom_range(0, 2) == 0)
               send_point(1'($urandom_range(0, 1)), pick_value(), pick_value());
            else
               send_point(1'($urandom_range(0, 1)), $urandom, $urandom);
         end
      end
   endtask

   initial begin
      matrix[0] = 32'h0001_0000;
      matrix[1] = '0;
      matrix[2] = '0;
      matrix[3] = 32'h0001_0000;
      matrix[4] = '0;
      matrix[5] = '0;
      repeat (9) @(negedge clock);
      reset = 1'b0;
      test_identity();
      test_spare_index();
      test_saturation();
      test_singular();
      test_negative_rounding();
      test_random(13, 80);
      drain();
      if (errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end
endmodule
